// ----- hw/rtl/wrst_pkg.sv -----
// Shared types and constants for the weighted random selection table.
package wrst_pkg;

    // Default sizes of the table and of one stored weight.
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_WEIGHT_BITS = 32;

    // Fixed field widths of the stream payloads.
    localparam int KIND_BITS     = 2;
    localparam int IN_WEIGHT_BITS = 32;
    localparam int SLOT_BITS     = 6;
    localparam int DRAW_BITS     = 38;
    localparam int INDEX_BITS    = 7;
    localparam int STATUS_BITS   = 2;
    localparam int SUM_BITS      = 38;

    // Packed payload widths, rounded up to whole bytes.
    localparam int IN_DATA_BITS  = 80;
    localparam int OUT_DATA_BITS = 56;

    // Operation codes carried in the input tuser.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PICK   = 2'd2
    } t_kind;

    // Result status codes carried in the output tuser.
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    // Per-cell control: load a new weight, or take the neighbor's weight.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/wrst_cell.sv -----
// One storage cell of the weight ring: holds a weight and takes its neighbor's.
module wrst_cell #(
    parameter int WEIGHT_BITS = wrst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                   i_clk,
    input  wrst_pkg::t_cell_ctrl   i_ctrl,
    input  logic [WEIGHT_BITS-1:0] i_new_weight,
    input  logic [WEIGHT_BITS-1:0] i_next_weight,
    output logic [WEIGHT_BITS-1:0] o_weight
);
    import wrst_pkg::*;

    logic [WEIGHT_BITS-1:0] r_weight;

    // A fresh weight has priority; otherwise the cell follows its neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_weight <= i_new_weight;
        end else if (i_ctrl.shift) begin
            r_weight <= i_next_weight;
        end
    end

    assign o_weight = r_weight;

endmodule

// ----- hw/rtl/weighted_random_selection_table_top.sv -----
// Top level of the weighted random selection table: ring of weight cells and its sequencer.
//
// The block keeps an ordered table of up to TABLE_DEPTH weights in a ring of
// cells, with a live entry count and the running total. Every input transfer
// gives exactly one output transfer. An append goes from input to result through
// the exec and finish states; a pick and a remove pass through the walk state,
// which rotates the whole ring once past the head cell, one entry per cycle,
// and so restores the table order at the end; a remove then closes the gap in
// the compact state. A rejected append, a remove with an out-of-range slot and
// the unused operation code go straight from exec to finish.
// One item is worked on at a time; a new input is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// The draw point for a pick comes from outside; the first index whose running
// sum exceeds it is returned, or the count when the point is not below the
// total. No clearing pass is needed after reset.
module weighted_random_selection_table_top #(
    parameter int TABLE_DEPTH = wrst_pkg::DEF_TABLE_DEPTH,
    parameter int WEIGHT_BITS = wrst_pkg::DEF_WEIGHT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata from bit 0: weight[31:0], slot[37:32], draw_point[75:38], zero fill.
    input  logic [wrst_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // tuser from bit 0: kind[1:0].
    input  logic [wrst_pkg::KIND_BITS-1:0]     i_s_axis_tuser,
    // Output stream.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata from bit 0: chosen_index[6:0], entry_count[13:7],
    // total_weight[51:14], zero fill.
    output logic [wrst_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // tuser from bit 0: status[1:0].
    output logic [wrst_pkg::STATUS_BITS-1:0]   o_m_axis_tuser
);
    import wrst_pkg::*;

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CW > SLOT_BITS) ? CW : SLOT_BITS;
    localparam int EXT_W  = CMP_W + INDEX_BITS;
    localparam int RUN_W  = WEIGHT_BITS + CW;
    localparam int DCMP_W = (RUN_W > DRAW_BITS) ? RUN_W : DRAW_BITS;
    localparam int W_LO   = 0;
    localparam int S_LO   = IN_WEIGHT_BITS;
    localparam int D_LO   = IN_WEIGHT_BITS + SLOT_BITS;
    localparam int PAD_W  = OUT_DATA_BITS - 2 * INDEX_BITS - SUM_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_COMPACT,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [KIND_BITS-1:0]   r_kind;
    logic [WEIGHT_BITS-1:0] r_weight;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [DRAW_BITS-1:0]   r_draw;
    logic [CW-1:0]          r_count;
    logic [SUM_BITS-1:0]    r_sum;
    logic [IW-1:0]          r_k;
    logic [RUN_W-1:0]       r_run;
    logic                   r_found;
    logic [CMP_W-1:0]       r_idx;
    t_status                r_status;
    logic [WEIGHT_BITS-1:0] r_rm_weight;
    logic                   r_out_valid;
    logic [INDEX_BITS-1:0]  r_out_idx;
    logic [INDEX_BITS-1:0]  r_out_count;
    logic [SUM_BITS-1:0]    r_out_sum;
    t_status                r_out_status;

    logic [WEIGHT_BITS-1:0] cell_weight [TABLE_DEPTH];
    logic [WEIGHT_BITS-1:0] head_weight;
    logic [CMP_W-1:0]       slot_ext;
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       k_ext;
    logic                   not_full;
    logic                   do_append;
    logic [RUN_W-1:0]       run_next;
    logic                   draw_hit;
    logic [EXT_W-1:0]       idx_wide;
    logic [EXT_W-1:0]       count_wide;

    // Compare operands brought to one width.
    assign head_weight = cell_weight[0];
    assign slot_ext    = CMP_W'(r_slot);
    assign count_ext   = CMP_W'(r_count);
    assign k_ext       = CMP_W'(r_k);
    assign not_full    = count_ext < CMP_W'(TABLE_DEPTH);
    assign do_append   = (r_state == S_EXEC) && (r_kind == KIND_APPEND) && not_full;
    assign run_next    = r_run + RUN_W'(head_weight);
    assign draw_hit    = DCMP_W'(r_draw) < DCMP_W'(run_next);
    assign idx_wide    = EXT_W'(r_idx);
    assign count_wide  = EXT_W'(r_count);

    // Ring of cells: each one hands its weight to the cell below it.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        t_cell_ctrl cell_ctrl;

        assign cell_ctrl.load  = do_append && (count_ext == CMP_W'(i));
        assign cell_ctrl.shift = (r_state == S_WALK)
                               || ((r_state == S_COMPACT) && (CMP_W'(i) >= slot_ext));

        wrst_cell #(
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_new_weight  (r_weight),
            .i_next_weight (cell_weight[(i + 1) % TABLE_DEPTH]),
            .o_weight      (cell_weight[i])
        );
    end

    // Sequencer: takes an item, walks the ring where needed, posts the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A result posted in the finish state replaces the one leaving.
            if (r_out_valid && i_m_axis_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_kind   <= i_s_axis_tuser;
                        r_weight <= i_s_axis_tdata[W_LO +: WEIGHT_BITS];
                        r_slot   <= i_s_axis_tdata[S_LO +: SLOT_BITS];
                        r_draw   <= i_s_axis_tdata[D_LO +: DRAW_BITS];
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_k      <= '0;
                    r_run    <= '0;
                    r_found  <= 1'b0;
                    r_status <= STAT_OK;
                    r_idx    <= count_ext;
                    unique case (r_kind)
                        KIND_APPEND: begin
                            if (not_full) begin
                                r_count <= r_count + 1'b1;
                                r_sum   <= r_sum + SUM_BITS'(r_weight);
                            end else begin
                                r_status <= STAT_FULL;
                            end
                            r_state <= S_FINISH;
                        end
                        KIND_REMOVE: begin
                            r_idx <= slot_ext;
                            if (slot_ext >= count_ext) begin
                                r_status <= STAT_RANGE;
                                r_state  <= S_FINISH;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                        KIND_PICK: begin
                            r_state <= S_WALK;
                        end
                        default: begin
                            r_idx   <= '0;
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_WALK: begin
                    // The head cell holds entry r_k during this cycle.
                    r_k <= r_k + 1'b1;
                    if ((r_kind == KIND_PICK) && (k_ext < count_ext) && !r_found) begin
                        r_run <= run_next;
                        if (draw_hit) begin
                            r_found <= 1'b1;
                            r_idx   <= k_ext;
                        end
                    end
                    if ((r_kind == KIND_REMOVE) && (k_ext == slot_ext)) begin
                        r_rm_weight <= head_weight;
                    end
                    if (r_k == IW'(TABLE_DEPTH - 1)) begin
                        r_state <= (r_kind == KIND_REMOVE) ? S_COMPACT : S_FINISH;
                    end
                end
                S_COMPACT: begin
                    r_count <= r_count - 1'b1;
                    r_sum   <= r_sum - SUM_BITS'(r_rm_weight);
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_idx    <= idx_wide[INDEX_BITS-1:0];
                        r_out_count  <= count_wide[INDEX_BITS-1:0];
                        r_out_sum    <= r_sum;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register drives the result stream.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_sum, r_out_count, r_out_idx};
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ----- verif/tb_weighted_random_selection_table_top.sv -----
// Self-checking testbench for the weighted random selection table top level.
`timescale 1ns / 100ps

module tb_weighted_random_selection_table_top;
    import wrst_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int HOLD_CYCLES = 400;
    localparam int RUN_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASE_ITEMS = 300;
    localparam int BIAS_ITEMS = 75;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    // How slot and draw point are chosen when an operation is loaded.
    typedef enum logic [1:0] {
        SEL_RAW,
        SEL_FIT,
        SEL_EDGE
    } field_mode_e;

    // Operation mix of a stretch of random operations.
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } op_mix_e;

    // One operation waiting to be sent.
    typedef struct {
        logic [KIND_BITS-1:0]      kind;
        logic [IN_WEIGHT_BITS-1:0] weight;
        logic [SLOT_BITS-1:0]      slot;
        logic [DRAW_BITS-1:0]      draw;
        field_mode_e               slot_mode;
        field_mode_e               draw_mode;
        int                        phase;
        bit                        hold;
        bit                        drain;
    } op_item_t;

    // One expected selection result.
    typedef struct {
        logic [INDEX_BITS-1:0] index;
        t_status               status;
        logic [INDEX_BITS-1:0] count;
        logic [SUM_BITS-1:0]   total;
    } sel_result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata = '0;
    logic [KIND_BITS-1:0]     i_s_axis_tuser = '0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic [STATUS_BITS-1:0]   o_m_axis_tuser;

    // Idle and stall percentages per traffic phase.
    int send_idle_pct [4] = '{0, 58, 0, 38};
    int recv_stall_pct [4] = '{0, 0, 58, 38};

    op_item_t    pending_ops[$];
    sel_result_t expected_selections[$];
    op_item_t    active_op;
    int          cur_phase = 0;
    logic        hold_kick = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          ops_accepted = 0;
    int          ops_total = 0;
    int          error_count = 0;

    // Shadow copy of the table contents.
    logic [IN_WEIGHT_BITS-1:0] shadow_weights [TABLE_DEPTH];
    int unsigned               shadow_count = 0;
    logic [SUM_BITS-1:0]       shadow_total = '0;

    // Coverage tallies for the closing summary.
    int n_append = 0, n_full = 0, n_remove = 0, n_range = 0;
    int n_pick_hit = 0, n_pick_miss = 0, n_unused = 0, max_count = 0;

    weighted_random_selection_table_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Applies one operation to the shadow table and returns the result it must give.
    function automatic sel_result_t compute_selection(op_item_t op);
        sel_result_t         res;
        logic [SUM_BITS-1:0] running;
        bit                  found;
        res.index = '0;
        res.status = STAT_OK;
        case (op.kind)
            KIND_APPEND: begin
                res.index = INDEX_BITS'(shadow_count);
                if (shadow_count >= TABLE_DEPTH) begin
                    res.status = STAT_FULL;
                    n_full++;
                end else begin
                    shadow_weights[shadow_count] = op.weight;
                    shadow_count++;
                    shadow_total = shadow_total + SUM_BITS'(op.weight);
                    n_append++;
                end
            end
            KIND_REMOVE: begin
                res.index = INDEX_BITS'(op.slot);
                if (op.slot >= shadow_count) begin
                    res.status = STAT_RANGE;
                    n_range++;
                end else begin
                    shadow_total = shadow_total - SUM_BITS'(shadow_weights[op.slot]);
                    for (int i = op.slot; i + 1 < shadow_count; i++) begin
                        shadow_weights[i] = shadow_weights[i + 1];
                    end
                    shadow_count--;
                    n_remove++;
                end
            end
            KIND_PICK: begin
                res.index = INDEX_BITS'(shadow_count);
                running = '0;
                found = 1'b0;
                for (int i = 0; i < shadow_count && !found; i++) begin
                    running = running + SUM_BITS'(shadow_weights[i]);
                    if (op.draw < running) begin
                        res.index = INDEX_BITS'(i);
                        found = 1'b1;
                    end
                end
                if (found) n_pick_hit++;
                else n_pick_miss++;
            end
            default: begin
                n_unused++;
            end
        endcase
        if (shadow_count > max_count) max_count = int'(shadow_count);
        res.count = INDEX_BITS'(shadow_count);
        res.total = shadow_total;
        return res;
    endfunction

    task automatic add_op(input logic [KIND_BITS-1:0] kind, input logic [31:0] weight,
                          input logic [5:0] slot, input logic [37:0] draw,
                          input field_mode_e slot_mode, input field_mode_e draw_mode,
                          input int phase, input bit hold, input bit drain);
        op_item_t op;
        op.kind = kind;
        op.weight = weight;
        op.slot = slot;
        op.draw = draw;
        op.slot_mode = slot_mode;
        op.draw_mode = draw_mode;
        op.phase = phase;
        op.hold = hold;
        op.drain = drain;
        pending_ops.push_back(op);
    endtask

    // Driver: records accepted transfers and offers the next pending operation.
    always @(posedge i_clk) begin : drive_proc
        bit                  fire;
        bit                  load;
        logic [SUM_BITS-1:0] r38;
        fire = i_s_axis_tvalid && o_s_axis_tready;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            hold_kick <= 1'b0;
        end else begin
            load = 1'b0;
            if (fire) begin
                expected_selections.push_back(compute_selection(active_op));
                ops_accepted++;
            end
            if (!i_s_axis_tvalid || fire) begin
                if (pending_ops.size() != 0
                        && !(pending_ops[0].drain && expected_selections.size() != 0)
                        && $urandom_range(99) >= send_idle_pct[pending_ops[0].phase]) begin
                    active_op = pending_ops.pop_front();
                    load = 1'b1;
                    // Slots and draw points relative to the table as it stands now.
                    r38[37:32] = 6'($urandom_range(63));
                    r38[31:0] = $urandom();
                    if (active_op.slot_mode == SEL_FIT && shadow_count != 0) begin
                        active_op.slot = SLOT_BITS'($urandom_range(shadow_count - 1));
                    end else if (active_op.slot_mode == SEL_EDGE) begin
                        if (shadow_count >= TABLE_DEPTH)
                            active_op.slot = SLOT_BITS'(TABLE_DEPTH - 1);
                        else if (shadow_count == 0 || $urandom_range(1) == 0)
                            active_op.slot = SLOT_BITS'(shadow_count);
                        else active_op.slot = SLOT_BITS'(shadow_count - 1);
                    end
                    if (active_op.draw_mode == SEL_FIT && shadow_total != 0) begin
                        active_op.draw = r38 % shadow_total;
                    end else if (active_op.draw_mode == SEL_EDGE) begin
                        if (shadow_total == 0 || $urandom_range(1) == 0)
                            active_op.draw = shadow_total;
                        else active_op.draw = shadow_total - 1'b1;
                    end
                    i_s_axis_tdata <= {4'd0, active_op.draw, active_op.slot, active_op.weight};
                    i_s_axis_tuser <= active_op.kind;
                    cur_phase <= active_op.phase;
                end
                i_s_axis_tvalid <= load;
            end
            hold_kick <= load && active_op.hold;
        end
    end

    // Long receiver hold-off, counted here so the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks every result transfer against the oldest expected selection.
    always @(posedge i_clk) begin : monitor_proc
        sel_result_t exp_res;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_selections.size() == 0) begin
                    $display("%0t: result with nothing expected: tdata %h tuser %0d",
                             $time, o_m_axis_tdata, o_m_axis_tuser);
                    error_count++;
                end else begin
                    exp_res = expected_selections.pop_front();
                    if (o_m_axis_tdata[6:0] !== exp_res.index) begin
                        $display("%0t: chosen_index expected %0d actual %0d",
                                 $time, exp_res.index, o_m_axis_tdata[6:0]);
                        error_count++;
                    end
                    if (o_m_axis_tuser !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, o_m_axis_tuser);
                        error_count++;
                    end
                    if (o_m_axis_tdata[13:7] !== exp_res.count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, exp_res.count, o_m_axis_tdata[13:7]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[51:14] !== exp_res.total) begin
                        $display("%0t: total_weight expected %0d actual %0d",
                                 $time, exp_res.total, o_m_axis_tdata[51:14]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[55:52] !== 4'd0) begin
                        $display("%0t: tdata fill expected 0 actual %h",
                                 $time, o_m_axis_tdata[55:52]);
                        error_count++;
                    end
                end
            end
            i_m_axis_tready <= (hold_left == 0)
                               && ($urandom_range(99) >= recv_stall_pct[cur_phase]);
        end
    end

    // Run limit.
    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("tb_weighted_random_selection_table_top failed");
        $finish;
    end

    // Stimulus and end of run.
    initial begin : main_proc
        op_mix_e             mix;
        int                  r;
        logic [KIND_BITS-1:0] kind;
        logic [31:0]         weight;
        logic [37:0]         draw;
        field_mode_e         slot_mode;
        field_mode_e         draw_mode;

        // Directed: empty table, extreme weights, zero weights, ranges and the unused code.
        add_op(KIND_PICK, '0, '0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_REMOVE, '0, '0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_UNUSED, '1, '1, '1, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_APPEND, 32'hFFFF_FFFF, '0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_APPEND, 32'h0, '0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_APPEND, 32'h1, '0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_APPEND, 32'h0, '0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_PICK, '0, '0, 38'h0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_PICK, '0, '0, 38'hFFFF_FFFE, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_PICK, '0, '0, 38'hFFFF_FFFF, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_PICK, '0, '0, 38'h1_0000_0000, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_PICK, '0, '0, '1, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_REMOVE, '0, 6'd63, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_REMOVE, '0, 6'd4, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_REMOVE, '0, 6'd1, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_PICK, '0, '0, 38'hFFFF_FFFF, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_REMOVE, '0, 6'd0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_REMOVE, '0, 6'd1, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_PICK, '0, '0, 38'h0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_REMOVE, '0, 6'd0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_UNUSED, '0, '0, '0, SEL_RAW, SEL_RAW, 0, 0, 0);
        add_op(KIND_APPEND, 32'hAAAA_AAAA, 6'h2A, 38'h2A_AAAA_AAAA, SEL_RAW, SEL_RAW,
               0, 0, 0);
        add_op(KIND_APPEND, 32'h5555_5555, 6'h15, 38'h15_5555_5555, SEL_RAW, SEL_RAW,
               0, 0, 0);
        add_op(KIND_PICK, '0, '0, '0, SEL_RAW, SEL_EDGE, 0, 0, 0);

        // Random: stretches that fill, drain or mix, across four traffic phases.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ((i / BIAS_ITEMS) % 4)
                0, 1: mix = MIX_FILL;
                2: mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            r = $urandom_range(99);
            case (mix)
                MIX_FILL: kind = (r < 70) ? KIND_APPEND : (r < 80) ? KIND_REMOVE :
                                 (r < 98) ? KIND_PICK : KIND_UNUSED;
                MIX_DRAIN: kind = (r < 12) ? KIND_APPEND : (r < 82) ? KIND_REMOVE :
                                  (r < 98) ? KIND_PICK : KIND_UNUSED;
                default: kind = (r < 40) ? KIND_APPEND : (r < 65) ? KIND_REMOVE :
                                (r < 98) ? KIND_PICK : KIND_UNUSED;
            endcase
            case ($urandom_range(9))
                0: weight = 32'h0;
                1: weight = 32'hFFFF_FFFF;
                2: weight = $urandom_range(15, 1);
                3, 4: weight = $urandom_range(1000, 1);
                default: weight = $urandom();
            endcase
            draw[37:32] = 6'($urandom_range(63));
            draw[31:0] = $urandom();
            r = $urandom_range(99);
            slot_mode = (r < 80) ? SEL_FIT : (r < 90) ? SEL_EDGE : SEL_RAW;
            r = $urandom_range(99);
            draw_mode = (r < 70) ? SEL_FIT : (r < 85) ? SEL_EDGE : SEL_RAW;
            add_op(kind, weight, 6'($urandom_range(63)), draw, slot_mode, draw_mode,
                   i / PHASE_ITEMS, (i == 150) || (i == 1050), (i % PHASE_ITEMS) == 0);
        end
        ops_total = pending_ops.size();

        // Synchronous reset, then released.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (ops_accepted == ops_total);
        wait (expected_selections.size() == 0);
        repeat (2 * TABLE_DEPTH + 16) @(posedge i_clk);

        $display("Covered %0d operations: %0d appends, %0d full, %0d removes, %0d out of range,",
                 ops_total, n_append, n_full, n_remove, n_range);
        $display("%0d picks hit, %0d picks past the total, %0d unused codes, peak count %0d.",
                 n_pick_hit, n_pick_miss, n_unused, max_count);
        if (error_count == 0 && expected_selections.size() == 0) begin
            $display("tb_weighted_random_selection_table_top passed");
        end else begin
            $display("tb_weighted_random_selection_table_top failed");
        end
        $finish;
    end

endmodule

// ----- weighted_random_selection_table_top.f -----
hw/rtl/wrst_pkg.sv
hw/rtl/wrst_cell.sv
hw/rtl/weighted_random_selection_table_top.sv
verif/tb_weighted_random_selection_table_top.sv
